@@ rtl/core/icalc_pkg.sv @@
// Shared types and constants for the integer calculator ALU.
// Used by the channel interfaces, the iterative units and the top level.
// No dependencies.
package icalc_pkg;

	localparam int OPND_W = 64;
	localparam int OP_W   = 3;

	typedef enum logic [OP_W-1:0] {
		OP_ADD  = 3'd0,
		OP_SUB  = 3'd1,
		OP_MUL  = 3'd2,
		OP_DIV  = 3'd3,
		OP_POW  = 3'd4,
		OP_FACT = 3'd5
	} op_t;

	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_DIV_ZERO = 1'b1;

	// Handshake status of a multi-cycle unit back to its sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

endpackage

@@ rtl/core/icalc_req_if.sv @@
// Request channel of the integer calculator ALU: opcode and two operands.
// Depends on icalc_pkg.
interface icalc_req_if;
	import icalc_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          op;
	logic signed [OPND_W-1:0] operand_a;
	logic signed [OPND_W-1:0] operand_b;

	modport source (output valid, op, operand_a, operand_b, input ready);
	modport sink   (input valid, op, operand_a, operand_b, output ready);
endinterface

@@ rtl/core/icalc_rsp_if.sv @@
// Response channel of the integer calculator ALU: result value and status.
// Depends on icalc_pkg.
interface icalc_rsp_if;
	import icalc_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [OPND_W-1:0] result_value;
	logic                     status;

	modport source (output valid, result_value, status, input ready);
	modport sink   (input valid, result_value, status, output ready);
endinterface

@@ rtl/core/icalc_mul.sv @@
// Iterative multiplier: one 16-bit digit of the multiplier per cycle,
// product wrapped to DATA_WIDTH bits. Depends on icalc_pkg (status struct).
module icalc_mul #(
	parameter int DATA_WIDTH = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [DATA_WIDTH-1:0]   a,
	input  logic [DATA_WIDTH-1:0]   b,
	output logic [DATA_WIDTH-1:0]   product,
	output icalc_pkg::unit_sts_t    sts
);
	localparam int DigW   = 16;
	localparam int NumDig = (DATA_WIDTH + DigW - 1) / DigW;
	localparam int PadW   = NumDig * DigW;
	localparam int CntW   = (NumDig > 1) ? $clog2(NumDig) : 1;
	localparam int PpW    = DATA_WIDTH + DigW;

	logic [DATA_WIDTH-1:0] mcand_q;
	logic [DATA_WIDTH-1:0] acc_q;
	logic [PadW-1:0]       mplier_q;
	logic [CntW-1:0]       cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [PpW-1:0]        pp;

	// Partial product of the shifted multiplicand and the lowest digit.
	assign pp = PpW'(mcand_q) * PpW'(mplier_q[DigW-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mcand_q  <= '0;
			acc_q    <= '0;
			mplier_q <= '0;
			cnt_q    <= '0;
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
		end else if (start) begin
			mcand_q  <= a;
			mplier_q <= PadW'(b);
			acc_q    <= '0;
			cnt_q    <= CntW'(NumDig - 1);
			busy_q   <= 1'b1;
			done_q   <= 1'b0;
		end else if (busy_q) begin
			acc_q    <= acc_q + pp[DATA_WIDTH-1:0];
			mcand_q  <= mcand_q << DigW;
			mplier_q <= mplier_q >> DigW;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign product  = acc_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;
endmodule

@@ rtl/core/icalc_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on icalc_pkg (status struct).
module icalc_div #(
	parameter int DATA_WIDTH = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [DATA_WIDTH-1:0]   dividend,
	input  logic [DATA_WIDTH-1:0]   divisor,
	output logic [DATA_WIDTH-1:0]   quotient,
	output icalc_pkg::unit_sts_t    sts
);
	localparam int CntW = $clog2(DATA_WIDTH);

	logic [DATA_WIDTH-1:0] rem_q;
	logic [DATA_WIDTH-1:0] quo_q;
	logic [DATA_WIDTH-1:0] dvsr_q;
	logic [CntW-1:0]       cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [DATA_WIDTH:0]   rem_sh;
	logic [DATA_WIDTH:0]   diff;
	logic                  fits;

	// The dividend shifts out of the quotient register as quotient bits enter.
	assign rem_sh = {rem_q, quo_q[DATA_WIDTH-1]};
	assign diff   = rem_sh - {1'b0, dvsr_q};
	assign fits   = !diff[DATA_WIDTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			quo_q  <= '0;
			dvsr_q <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			rem_q  <= '0;
			quo_q  <= dividend;
			dvsr_q <= divisor;
			cnt_q  <= CntW'(DATA_WIDTH - 1);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DATA_WIDTH-1:0] : rem_sh[DATA_WIDTH-1:0];
			quo_q <= {quo_q[DATA_WIDTH-2:0], fits};
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign quotient = quo_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;
endmodule

@@ rtl/core/integer_calculator_alu_core.sv @@
// Add, subtract and unused opcodes go from S_IDLE through S_OUT to the output register;
// multiply waits in S_MUL for its ND = ceil(DATA_WIDTH/16) digits, divide in S_DIV.
// Power runs up to a multiply and a squaring per exponent bit; factorial one multiply per factor,
// and the product reaches zero after at most about DATA_WIDTH+6 factors.
// The sequencer takes one request at a time and shares the digit multiplier and the bit-serial divider.
// Reset (arst_n low, asynchronous) empties the sequencer and the output register.
module integer_calculator_alu_core #(
	parameter int DATA_WIDTH = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	icalc_req_if.sink    req,
	icalc_rsp_if.source  rsp
);
	import icalc_pkg::*;

	localparam int W = DATA_WIDTH;

	// The sequencer walks one request through the shared units. Power is
	// square-and-multiply over the exponent bits; factorial multiplies the
	// running product by 1, 2, ... until the counter reaches the argument or
	// the wrapped product has become zero.
	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_DIV,
		S_POW_CHK,
		S_POW_ACC,
		S_POW_SQ,
		S_FACT_CHK,
		S_FACT_MUL,
		S_OUT
	} state_t;

	state_t                  state_q;
	logic [W-1:0]            acc_q;     // running result
	logic [W-1:0]            base_q;    // power base, or factorial argument
	logic [W-1:0]            cnt_q;     // remaining exponent, or factorial factor
	logic                    neg_q;     // quotient must be negated
	logic                    st_q;
	logic                    out_valid_q;
	logic [OPND_W-1:0]       out_value_q;
	logic                    out_status_q;

	logic                    accept;
	logic                    out_free;
	op_t                     in_op;
	logic [W-1:0]            in_a;
	logic [W-1:0]            in_b;
	logic [W-1:0]            a_mag;
	logic [W-1:0]            b_mag;

	logic                    mul_start;
	logic [W-1:0]            mul_a;
	logic [W-1:0]            mul_b;
	logic [W-1:0]            mul_prod;
	unit_sts_t               mul_sts;

	logic                    div_start;
	logic [W-1:0]            div_quo;
	unit_sts_t               div_sts;

	// Only the low DATA_WIDTH bits of each operand take part.
	assign in_op  = op_t'(req.op);
	assign in_a   = req.operand_a[W-1:0];
	assign in_b   = req.operand_b[W-1:0];
	assign a_mag  = in_a[W-1] ? ('0 - in_a) : in_a;
	assign b_mag  = in_b[W-1] ? ('0 - in_b) : in_b;

	// A new request is taken whenever the sequencer is free, even while the
	// previous result still sits in the output register.
	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;

	assign div_start = accept && (in_op == OP_DIV) && (in_b != '0);

	// Operand selection for the shared multiplier. A new multiply may be
	// started in the same cycle the previous one reports done.
	always_comb begin
		mul_start = 1'b0;
		mul_a     = acc_q;
		mul_b     = base_q;
		case (state_q)
			S_IDLE: begin
				if (accept && (in_op == OP_MUL)) begin
					mul_start = 1'b1;
					mul_a     = in_a;
					mul_b     = in_b;
				end
			end
			S_POW_CHK: begin
				if (cnt_q != '0) begin
					mul_start = 1'b1;
					if (!cnt_q[0]) begin
						mul_a = base_q;
					end
				end
			end
			S_POW_ACC: begin
				if (mul_sts.done && (cnt_q[W-1:1] != '0)) begin
					mul_start = 1'b1;
					mul_a     = base_q;
				end
			end
			S_FACT_CHK: begin
				if ((cnt_q < base_q) && (acc_q != '0)) begin
					mul_start = 1'b1;
					mul_b     = cnt_q;
				end
			end
			default: begin
			end
		endcase
	end

	icalc_mul #(
		.DATA_WIDTH (W)
	) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.product (mul_prod),
		.sts     (mul_sts)
	);

	icalc_div #(
		.DATA_WIDTH (W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (a_mag),
		.divisor  (b_mag),
		.quotient (div_quo),
		.sts      (div_sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			acc_q        <= '0;
			base_q       <= '0;
			cnt_q        <= '0;
			neg_q        <= 1'b0;
			st_q         <= STATUS_OK;
			out_valid_q  <= 1'b0;
			out_value_q  <= '0;
			out_status_q <= STATUS_OK;
		end else begin
			// Output register: cleared by a transfer, refilled from S_OUT.
			if (out_valid_q && rsp.ready && (state_q != S_OUT)) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						st_q <= ((in_op == OP_DIV) && (in_b == '0)) ?
							STATUS_DIV_ZERO : STATUS_OK;
						case (in_op)
							OP_ADD: begin
								acc_q   <= in_a + in_b;
								state_q <= S_OUT;
							end
							OP_SUB: begin
								acc_q   <= in_a - in_b;
								state_q <= S_OUT;
							end
							OP_MUL: state_q <= S_MUL;
							OP_DIV: begin
								if (in_b == '0) begin
									acc_q   <= '0;
									state_q <= S_OUT;
								end else begin
									neg_q   <= in_a[W-1] ^ in_b[W-1];
									state_q <= S_DIV;
								end
							end
							OP_POW: begin
								if (in_b[W-1]) begin
									// Negative exponent leaves the base.
									acc_q   <= in_a;
									state_q <= S_OUT;
								end else if (in_b == '0) begin
									acc_q   <= W'(1);
									state_q <= S_OUT;
								end else begin
									acc_q   <= W'(1);
									base_q  <= in_a;
									cnt_q   <= in_b;
									state_q <= S_POW_CHK;
								end
							end
							OP_FACT: begin
								if (in_a[W-1]) begin
									// Negative argument is returned as is.
									acc_q   <= in_a;
									state_q <= S_OUT;
								end else if (in_a == '0) begin
									acc_q   <= W'(1);
									state_q <= S_OUT;
								end else begin
									acc_q   <= in_a;
									base_q  <= in_a;
									cnt_q   <= W'(1);
									state_q <= S_FACT_CHK;
								end
							end
							default: begin
								acc_q   <= '0;
								state_q <= S_OUT;
							end
						endcase
					end
				end
				S_MUL: begin
					if (mul_sts.done) begin
						acc_q   <= mul_prod;
						state_q <= S_OUT;
					end
				end
				S_DIV: begin
					if (div_sts.done) begin
						acc_q   <= neg_q ? ('0 - div_quo) : div_quo;
						state_q <= S_OUT;
					end
				end
				S_POW_CHK: begin
					if (cnt_q == '0) begin
						state_q <= S_OUT;
					end else if (cnt_q[0]) begin
						state_q <= S_POW_ACC;
					end else begin
						state_q <= S_POW_SQ;
					end
				end
				S_POW_ACC: begin
					if (mul_sts.done) begin
						acc_q <= mul_prod;
						// The last squaring would never be used.
						if (cnt_q[W-1:1] == '0) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_POW_SQ;
						end
					end
				end
				S_POW_SQ: begin
					if (mul_sts.done) begin
						base_q  <= mul_prod;
						cnt_q   <= cnt_q >> 1;
						state_q <= S_POW_CHK;
					end
				end
				S_FACT_CHK: begin
					if (!((cnt_q < base_q) && (acc_q != '0))) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_FACT_MUL;
					end
				end
				S_FACT_MUL: begin
					if (mul_sts.done) begin
						acc_q   <= mul_prod;
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_FACT_CHK;
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_value_q  <= OPND_W'($signed(acc_q));
						out_status_q <= st_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.result_value = out_value_q;
	assign rsp.status       = out_status_q;

`ifndef SYNTHESIS
	// The multiplier is never restarted while it is still working.
	a_mul_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |-> !mul_sts.busy)
		else $error("multiplier started while busy");

	// A request is only taken when both units are free.
	a_accept_units_free: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (!mul_sts.busy && !div_sts.busy))
		else $error("request taken while a unit is busy");

	// Divider completion is only ever seen by the divide wait state.
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.done |-> (state_q == S_DIV))
		else $error("divider finished outside divide state");

	// A divide-by-zero result always carries a zero value.
	a_div_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status == STATUS_DIV_ZERO)) |-> (rsp.result_value == '0))
		else $error("divide-by-zero status with nonzero result");

	// Handing a result to the output register frees the sequencer next cycle.
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_OUT) && out_free) |=> (out_valid_q && (state_q == S_IDLE)))
		else $error("result not loaded into output register");
`endif
endmodule

@@ bench/icalc_checker.sv @@
`timescale 1ns / 1ps
// Checker for the integer calculator ALU: watches the request and response channels,
// predicts every result and compares it field by field. Depends on icalc_pkg and the
// icalc_req_if and icalc_rsp_if interfaces.
module icalc_checker (
	input  logic clk,
	input  logic arst_n,
	icalc_req_if req,
	icalc_rsp_if rsp,
	output int   mismatch_count,
	output int   outstanding
);
	import icalc_pkg::*;

	typedef struct packed {
		logic [OPND_W-1:0] value;
		logic              status;
	} alu_result_t;

	// All arithmetic is 64-bit two's complement and wraps.
	function automatic alu_result_t compute_alu_result(
		input logic [OP_W-1:0]   op,
		input logic [OPND_W-1:0] a,
		input logic [OPND_W-1:0] b
	);
		alu_result_t       r;
		logic [OPND_W-1:0] mag_a, mag_b, quo, base, acc, e, i;
		r.value  = '0;
		r.status = STATUS_OK;
		case (op)
		OP_ADD: r.value = a + b;
		OP_SUB: r.value = a - b;
		OP_MUL: r.value = a * b;
		OP_DIV: begin
			if (b == '0) begin
				r.status = STATUS_DIV_ZERO;
			end else begin
				// Divide magnitudes so that the most negative value cannot overflow.
				mag_a   = a[OPND_W-1] ? -a : a;
				mag_b   = b[OPND_W-1] ? -b : b;
				quo     = mag_a / mag_b;
				r.value = (a[OPND_W-1] ^ b[OPND_W-1]) ? -quo : quo;
			end
		end
		OP_POW: begin
			if (b[OPND_W-1]) begin
				r.value = a;
			end else begin
				acc  = OPND_W'(1);
				base = a;
				e    = b;
				while (e != '0) begin
					if (e[0])
						acc = acc * base;
					base = base * base;
					e    = e >> 1;
				end
				r.value = acc;
			end
		end
		OP_FACT: begin
			if (a[OPND_W-1]) begin
				r.value = a;
			end else if (a == '0) begin
				r.value = OPND_W'(1);
			end else begin
				acc = a;
				for (i = OPND_W'(1); i < a && acc != '0; i = i + OPND_W'(1))
					acc = acc * i;
				r.value = acc;
			end
		end
		default: ;
		endcase
		return r;
	endfunction

	alu_result_t results_due[$];
	alu_result_t due;
	int          errs;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results_due.delete();
			mismatch_count <= 0;
			outstanding    <= 0;
		end else begin
			errs = 0;
			// The response is checked before a request of the same edge is queued.
			if (rsp.valid && rsp.ready) begin
				if (results_due.size() == 0) begin
					$error("response transfer with no result due: result_value %0d status %0d",
						rsp.result_value, rsp.status);
					errs++;
				end else begin
					due = results_due.pop_front();
					if (rsp.result_value !== due.value) begin
						$error("result_value mismatch: expected %0d, actual %0d",
							$signed(due.value), rsp.result_value);
						errs++;
					end
					if (rsp.status !== due.status) begin
						$error("status mismatch: expected %0d, actual %0d",
							due.status, rsp.status);
						errs++;
					end
				end
			end
			if (req.valid && req.ready)
				results_due.push_back(compute_alu_result(req.op, req.operand_a, req.operand_b));
			mismatch_count <= mismatch_count + errs;
			outstanding    <= results_due.size();
		end
	end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench top for integer_calculator_alu_core: clock, reset, request stimulus,
// response back-pressure and the verdict. Depends on icalc_pkg, the channel
// interfaces and the icalc_checker module.
module tb_top;
	import icalc_pkg::*;

	localparam int HALF_PERIOD  = 5;
	localparam int RESET_CYCLES = 3;
	localparam int RANDOM_ITEMS = 1450;
	// Slowest item: a power with a 63-bit exponent, plus the sender's gaps and the
	// receiver's stalls. The limit allows several times its cost for every item.
	localparam int CYCLE_LIMIT  = 6_000_000;
	// Quiet cycles after the last result, so that a stray late transfer is caught.
	localparam int DRAIN_CYCLES = 100;

	// The two opcodes the block does not define; they must return zero with status ok.
	localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

	localparam logic [OPND_W-1:0] MOST_NEG  = {1'b1, {(OPND_W-1){1'b0}}};
	localparam logic [OPND_W-1:0] MOST_POS  = {1'b0, {(OPND_W-1){1'b1}}};
	localparam logic [OPND_W-1:0] MINUS_ONE = '1;

	logic       clk    = 1'b0;
	logic       arst_n = 1'b0;
	logic [7:0] stall_phase = '0;
	int         cycle_count = 0;
	int         burst_left  = 0;
	int         mismatch_count;
	int         outstanding;

	icalc_req_if req_ch ();
	icalc_rsp_if rsp_ch ();

	integer_calculator_alu_core #(
		.DATA_WIDTH(OPND_W)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// The checker sees every transfer on both channels and keeps the expected results.
	icalc_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req_ch),
		.rsp           (rsp_ch),
		.mismatch_count(mismatch_count),
		.outstanding   (outstanding)
	);

	always #HALF_PERIOD clk = ~clk;

	// The run ends here if the block hangs or the stimulus never drains.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// The receiver cycles through four stall patterns of equal length: always ready,
	// ready half the time, ready a quarter of the time, and a fixed on-off rhythm from the phase counter.
	// The period of the patterns does not line up with the block's latencies, so stalls land
	// on every phase of its work.
	always @(posedge clk) begin
		stall_phase <= stall_phase + 1'b1;
		case (stall_phase[7:6])
		2'd0:    rsp_ch.ready <= 1'b1;
		2'd1:    rsp_ch.ready <= 1'($urandom_range(0, 1));
		2'd2:    rsp_ch.ready <= ($urandom_range(0, 3) == 0);
		default: rsp_ch.ready <= stall_phase[2];
		endcase
	end

	// Operand mix: the corner values, small numbers around zero, sign-extended 32-bit
	// values, and full 64-bit random patterns so that every bit toggles.
	function automatic logic [OPND_W-1:0] pick_operand();
		logic [OPND_W-1:0] v;
		logic [31:0]       w;
		w = $urandom;
		case ($urandom_range(0, 9))
		0: begin
			case ($urandom_range(0, 4))
			0:       v = MOST_NEG;
			1:       v = MOST_POS;
			2:       v = '0;
			3:       v = MINUS_ONE;
			default: v = OPND_W'(1);
			endcase
		end
		1, 2:    v = OPND_W'($urandom_range(0, 200)) - OPND_W'(100);
		3, 4, 5: v = {{32{w[31]}}, w};
		default: v = {$urandom, $urandom};
		endcase
		return v;
	endfunction

	// Drives one request and returns at the edge where it transfers. The sender works
	// in bursts; between bursts valid drops for a random gap, and about a quarter of
	// the bursts follow the previous one with no gap at all. Valid is written at most
	// once per time step, so back-to-back requests keep it high.
	task automatic send_request(
		input logic [OP_W-1:0]   op,
		input logic [OPND_W-1:0] a,
		input logic [OPND_W-1:0] b
	);
		int gap;
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = $urandom_range(1, 40);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_ch.valid     <= 1'b1;
		req_ch.op        <= op;
		req_ch.operand_a <= a;
		req_ch.operand_b <= b;
		do
			@(posedge clk);
		while (!req_ch.ready);
	endtask

	// Holds the request channel idle until every expected result has come back. The
	// checker's count is registered and lags the transfer, so it is read only from the next edge.
	task automatic wait_for_results();
		req_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
	endtask

	initial begin
		int                n;
		int                sel;
		logic [OP_W-1:0]   op;
		logic [OPND_W-1:0] a;
		logic [OPND_W-1:0] b;

		req_ch.valid     = 1'b0;
		req_ch.op        = OP_ADD;
		req_ch.operand_a = '0;
		req_ch.operand_b = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: wrap-around at both ends of the range for add, subtract and
		// multiply.
		send_request(OP_ADD, MOST_POS, 64'sd1);
		send_request(OP_ADD, MOST_NEG, MOST_NEG);
		send_request(OP_SUB, MOST_NEG, 64'sd1);
		send_request(OP_SUB, '0, MOST_NEG);
		send_request(OP_MUL, MOST_POS, MOST_POS);
		send_request(OP_MUL, MOST_NEG, MINUS_ONE);
		send_request(OP_MUL, -64'sd3, 64'sd7);
		// Division: by zero, the overflowing most negative by minus one, and truncation
		// toward zero with a negative dividend, a negative divisor or both.
		send_request(OP_DIV, 64'sd7, '0);
		send_request(OP_DIV, '0, '0);
		send_request(OP_DIV, MOST_NEG, MINUS_ONE);
		send_request(OP_DIV, -64'sd7, 64'sd2);
		send_request(OP_DIV, 64'sd7, -64'sd2);
		send_request(OP_DIV, MINUS_ONE, MOST_NEG);
		// Power: exponent zero with base zero, a negative exponent, exponent one, a result
		// that wraps, one that wraps to zero, and the longest exponent.
		send_request(OP_POW, '0, '0);
		send_request(OP_POW, 64'sd5, -64'sd3);
		send_request(OP_POW, -64'sd3, 64'sd1);
		send_request(OP_POW, 64'sd3, 64'sd40);
		send_request(OP_POW, 64'sd2, 64'sd64);
		send_request(OP_POW, 64'sd7, MOST_POS);
		// Factorial: zero, one, a negative argument, the largest that fits, one that
		// wraps, and a huge argument whose product runs into zero.
		send_request(OP_FACT, '0, MINUS_ONE);
		send_request(OP_FACT, 64'sd1, '0);
		send_request(OP_FACT, -64'sd5, 64'sd9);
		send_request(OP_FACT, 64'sd20, '0);
		send_request(OP_FACT, 64'sd25, '0);
		send_request(OP_FACT, MOST_POS, MOST_NEG);
		send_request(OP_SPARE_LO, MOST_POS, MOST_POS);
		send_request(OP_SPARE_HI, MINUS_ONE, 64'sd1);

		// The block must sit idle with nothing outstanding and pick up cleanly afterwards.
		wait_for_results();

		// Random part. Each operation gets operands shaped toward its own corners: zero
		// divisors and the overflow case for divide, short, negative and long exponents for
		// power, and small, medium and negative arguments for factorial.
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 2)
				wait_for_results();
			sel = $urandom_range(0, 99);
			a   = pick_operand();
			b   = pick_operand();
			if (sel < 14) begin
				op = OP_ADD;
			end else if (sel < 28) begin
				op = OP_SUB;
			end else if (sel < 44) begin
				op = OP_MUL;
			end else if (sel < 62) begin
				op = OP_DIV;
				case ($urandom_range(0, 9))
				0: b = '0;
				1: begin
					a = MOST_NEG;
					b = MINUS_ONE;
				end
				default: ;
				endcase
			end else if (sel < 78) begin
				op = OP_POW;
				case ($urandom_range(0, 3))
				0: b = OPND_W'($urandom_range(0, 70));
				1: b = {1'b1, 31'($urandom), 32'($urandom)};
				2: ;
				default: b = OPND_W'($urandom);
				endcase
			end else if (sel < 95) begin
				op = OP_FACT;
				case ($urandom_range(0, 4))
				0, 1: a = OPND_W'($urandom_range(0, 30));
				2:    a = OPND_W'($urandom_range(31, 200));
				3:    a = {1'b1, 31'($urandom), 32'($urandom)};
				default: ;
				endcase
			end else begin
				op = sel[0] ? OP_SPARE_HI : OP_SPARE_LO;
			end
			send_request(op, a, b);
		end

		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
